### rtl/caed_pkg.sv
// Shared types and constants for the angle encoder CAN frame decoder.
// No dependencies; caed_div, the core and the testbench take names from here by scope.
`default_nettype none
package caed_pkg;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_EMIT
	} state_t;

	// Input command codes
	typedef enum logic [1:0] {
		CMD_FRAME   = 2'd0,
		CMD_REQUEST = 2'd1,
		CMD_CLEAR   = 2'd2
	} cmd_t;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_INVALID  = 3'd0,
		KIND_NOT_ADDR = 3'd1,
		KIND_MEASURE  = 3'd2,
		KIND_TEMP     = 3'd3,
		KIND_REPLY    = 3'd4,
		KIND_REQUEST  = 3'd5,
		KIND_CLEARED  = 3'd6
	} kind_t;

	// Configuration register indexes
	localparam logic [1:0] REG_DEVICE_ID   = 2'd0;
	localparam logic [1:0] REG_SAMPLE_PER  = 2'd1;
	localparam logic [1:0] REG_STALE_LIMIT = 2'd2;

	// Register reset values
	localparam logic [10:0] DEVICE_ID_RST   = 11'd0;
	localparam logic [15:0] SAMPLE_PER_RST  = 16'd10;
	localparam logic [31:0] STALE_LIMIT_RST = 32'd100;

	// Frame bytes
	localparam logic [7:0] SYNC_BYTE    = 8'h55;
	localparam logic [7:0] TYPE_MEASURE = 8'h55;
	localparam logic [7:0] TYPE_TEMP    = 8'h56;
	localparam logic [7:0] TYPE_REPLY   = 8'h5F;
	localparam logic [3:0] FRAME_LEN    = 4'd8;
	localparam logic [7:0] NO_PENDING   = 8'hFF;

	// Read request bytes
	localparam logic [7:0] REQ_HEAD0 = 8'hFF;
	localparam logic [7:0] REQ_HEAD1 = 8'hAA;
	localparam logic [7:0] REQ_READ  = 8'h27;
	localparam logic [7:0] REQ_TAIL  = 8'h00;

	// Scale factors: 360000/32768 = 11250/1024, 3.6e9/32768 = 3515625/32
	localparam logic [13:0] ANGLE_MUL   = 14'd11250;
	localparam int          ANGLE_SHIFT = 10;
	localparam logic [21:0] VEL_MUL     = 22'd3515625;
	localparam int          VEL_SHIFT   = 5;

	// Saturation bounds of the velocity
	localparam logic [31:0] VEL_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] VEL_MIN = 32'h8000_0000;

	// Divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	// Registered result item
	typedef struct packed {
		kind_t              kind;
		logic [19:0]        angle_millideg;
		logic signed [31:0] velocity_mdeg_s;
		logic signed [15:0] turns;
		logic signed [19:0] temp_mdeg_c;
		logic [7:0]         reply_start;
		logic [47:0]        reply_words;
		logic [39:0]        request_bytes;
		logic               measure_fresh;
		logic               temp_fresh;
		logic [31:0]        bad_frames;
	} out_item_t;

endpackage
`default_nettype wire

### rtl/caed_in_if.sv
// Input item channel of the angle encoder frame decoder.
// Stands alone; carries valid, ready and the command fields.
`default_nettype none
interface caed_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [28:0] rx_id;
	logic        rx_extended;
	logic [3:0]  rx_length;
	logic [63:0] rx_payload;
	logic [7:0]  reg_addr;
	logic [31:0] time_ms;

	modport source (output valid, command, rx_id, rx_extended, rx_length, rx_payload,
		reg_addr, time_ms, input ready);
	modport sink (input valid, command, rx_id, rx_extended, rx_length, rx_payload,
		reg_addr, time_ms, output ready);
endinterface
`default_nettype wire

### rtl/caed_out_if.sv
// Result item channel of the angle encoder frame decoder.
// Stands alone; carries valid, ready and the decoded fields.
`default_nettype none
interface caed_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [19:0]        angle_millideg;
	logic signed [31:0] velocity_mdeg_s;
	logic signed [15:0] turns;
	logic signed [19:0] temp_mdeg_c;
	logic [7:0]         reply_start;
	logic [47:0]        reply_words;
	logic [39:0]        request_bytes;
	logic               measure_fresh;
	logic               temp_fresh;
	logic [31:0]        bad_frames;

	modport source (output valid, kind, angle_millideg, velocity_mdeg_s, turns, temp_mdeg_c,
		reply_start, reply_words, request_bytes, measure_fresh, temp_fresh, bad_frames,
		input ready);
	modport sink (input valid, kind, angle_millideg, velocity_mdeg_s, turns, temp_mdeg_c,
		reply_start, reply_words, request_bytes, measure_fresh, temp_fresh, bad_frames,
		output ready);
endinterface
`default_nettype wire

### rtl/caed_cfg_if.sv
// Configuration write channel of the angle encoder frame decoder.
// Stands alone; carries valid, ready, register index and write data.
`default_nettype none
interface caed_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/caed_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, a 32-bit quotient per run.
// Depends on caed_pkg for the status struct.
`default_nettype none
module caed_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [31:0]       dividend,
	input  wire logic [15:0]       divisor,
	output caed_pkg::div_sts_t     sts,
	output logic [31:0]            quotient
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [15:0] rem_q;
	logic [31:0] quo_q;
	logic [15:0] dvs_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        ge;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, quo_q[31]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	// Control: run for 32 steps, pulse done at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then one restoring step per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

### rtl/can_angle_encoder_frame_decoder_core.sv
// Angle encoder CAN frame decoder, top level.
// Flow: an accepted item goes from ST_IDLE through ST_MUL and ST_EMIT to the result
// register; a measurement frame also waits in ST_DIV for the 32-step serial velocity
// divider. One item at a time; ST_IDLE takes the next once the last one has fired.
// The result register lets the next item in while a result waits to be taken.
// Reset clears all stored data and loads device_id 0, sample_period 10, stale 100 ms.
`default_nettype none
module can_angle_encoder_frame_decoder_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	caed_in_if.sink      item,
	caed_out_if.source   res,
	caed_cfg_if.sink     cfg
);

	caed_pkg::state_t state_q, state_nx;

	// Configuration registers
	logic [10:0] dev_id_q;
	logic [15:0] sample_per_q;
	logic [31:0] stale_q;

	// Captured item
	logic [1:0]  cmd_q;
	logic [28:0] id_q;
	logic        ext_q;
	logic [3:0]  len_q;
	logic [63:0] pay_q;
	logic [7:0]  addr_q;
	logic [31:0] time_q;
	logic [19:0] angle_calc_q;

	// Stored state
	logic [19:0]        angle_q;
	logic signed [31:0] vel_q;
	logic signed [15:0] turns_q;
	logic signed [19:0] temp_q;
	logic [7:0]         reply_start_q;
	logic [47:0]        reply_words_q;
	logic [31:0]        mtime_q;
	logic [31:0]        ttime_q;
	logic               mseen_q;
	logic               tseen_q;
	logic [7:0]         pend_addr_q;
	logic               pend_q;
	logic [31:0]        bad_q;

	// Next stored state
	logic [19:0]        angle_nx;
	logic signed [31:0] vel_nx;
	logic signed [15:0] turns_nx;
	logic signed [19:0] temp_nx;
	logic [7:0]         reply_start_nx;
	logic [47:0]        reply_words_nx;
	logic [31:0]        mtime_nx;
	logic [31:0]        ttime_nx;
	logic               mseen_nx;
	logic               tseen_nx;
	logic [7:0]         pend_addr_nx;
	logic               pend_nx;
	logic [31:0]        bad_nx;
	logic [39:0]        req_nx;
	caed_pkg::kind_t    kind_nx;

	caed_pkg::out_item_t out_q;
	logic                out_valid_q;

	logic               accept;
	logic               fire;
	logic               addressed;
	logic               hdr_ok;
	logic [7:0]         type_byte;
	logic               is_measure;
	logic [29:0]        angle_prod;
	logic signed [15:0] vel_raw;
	logic [16:0]        vel_mag;
	logic [38:0]        vel_prod;
	logic [15:0]        divisor;
	logic               div_start;
	caed_pkg::div_sts_t div_sts;
	logic [31:0]        div_quo;
	logic signed [31:0] vel_sat;
	logic [19:0]        temp_ext;
	logic [31:0]        m_age;
	logic [31:0]        t_age;

	// Frame classification from the captured item
	always_comb begin
		addressed  = !ext_q && (id_q == {18'd0, dev_id_q});
		hdr_ok     = (len_q == caed_pkg::FRAME_LEN) && (pay_q[7:0] == caed_pkg::SYNC_BYTE);
		type_byte  = pay_q[15:8];
		is_measure = (cmd_q == caed_pkg::CMD_FRAME) && addressed && hdr_ok
			&& (type_byte == caed_pkg::TYPE_MEASURE);
	end

	// Angle scaling at capture time
	assign angle_prod = 30'(item.rx_payload[31:16] * caed_pkg::ANGLE_MUL);

	// Velocity magnitude scaled by 3.6e9/32768, fed to the divider
	always_comb begin
		vel_raw  = $signed(pay_q[47:32]);
		vel_mag  = vel_raw[15] ? 17'(-{vel_raw[15], vel_raw}) : {1'b0, vel_raw};
		vel_prod = 39'(vel_mag * caed_pkg::VEL_MUL);
		divisor  = (sample_per_q == '0) ? 16'd1 : sample_per_q;
	end

	caed_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (vel_prod[caed_pkg::VEL_SHIFT +: 32]),
		.divisor  (divisor),
		.sts      (div_sts),
		.quotient (div_quo)
	);

	// Apply sign and saturate to 32 bits
	always_comb begin
		if (vel_raw[15]) begin
			vel_sat = (div_quo[31] && (|div_quo[30:0])) ? $signed(caed_pkg::VEL_MIN)
				: $signed(-div_quo);
		end else begin
			vel_sat = div_quo[31] ? $signed(caed_pkg::VEL_MAX) : $signed(div_quo);
		end
	end

	// Sequencer: next state and handshake outputs
	always_comb begin
		state_nx  = state_q;
		accept    = 1'b0;
		fire      = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			caed_pkg::ST_IDLE: begin
				accept = item.valid;
				if (item.valid) state_nx = caed_pkg::ST_MUL;
			end
			caed_pkg::ST_MUL: begin
				if (is_measure) begin
					div_start = 1'b1;
					state_nx  = caed_pkg::ST_DIV;
				end else begin
					state_nx = caed_pkg::ST_EMIT;
				end
			end
			caed_pkg::ST_DIV: begin
				if (div_sts.done && !div_sts.busy) state_nx = caed_pkg::ST_EMIT;
			end
			caed_pkg::ST_EMIT: begin
				if (!out_valid_q || res.ready) begin
					fire     = 1'b1;
					state_nx = caed_pkg::ST_IDLE;
				end
			end
			default: state_nx = caed_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= caed_pkg::ST_IDLE;
		else         state_q <= state_nx;
	end

	// Capture the item
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= item.command;
			id_q         <= item.rx_id;
			ext_q        <= item.rx_extended;
			len_q        <= item.rx_length;
			pay_q        <= item.rx_payload;
			addr_q       <= item.reg_addr;
			time_q       <= item.time_ms;
			angle_calc_q <= angle_prod[caed_pkg::ANGLE_SHIFT +: 20];
		end
	end

	// Decide the update of the stored state
	always_comb begin
		angle_nx       = angle_q;
		vel_nx         = vel_q;
		turns_nx       = turns_q;
		temp_nx        = temp_q;
		reply_start_nx = reply_start_q;
		reply_words_nx = reply_words_q;
		mtime_nx       = mtime_q;
		ttime_nx       = ttime_q;
		mseen_nx       = mseen_q;
		tseen_nx       = tseen_q;
		pend_addr_nx   = pend_addr_q;
		pend_nx        = pend_q;
		bad_nx         = bad_q;
		req_nx         = '0;
		kind_nx        = caed_pkg::KIND_INVALID;
		temp_ext       = {{4{pay_q[31]}}, pay_q[31:16]};
		unique case (cmd_q)
			caed_pkg::CMD_FRAME: begin
				if (!addressed) begin
					kind_nx = caed_pkg::KIND_NOT_ADDR;
				end else if (!hdr_ok) begin
					bad_nx = bad_q + 32'd1;
				end else if (type_byte == caed_pkg::TYPE_MEASURE) begin
					kind_nx  = caed_pkg::KIND_MEASURE;
					angle_nx = angle_calc_q;
					vel_nx   = vel_sat;
					turns_nx = $signed(pay_q[63:48]);
					mtime_nx = time_q;
					mseen_nx = 1'b1;
				end else if (type_byte == caed_pkg::TYPE_TEMP) begin
					kind_nx  = caed_pkg::KIND_TEMP;
					temp_nx  = $signed((temp_ext << 3) + (temp_ext << 1));
					ttime_nx = time_q;
					tseen_nx = 1'b1;
				end else if (type_byte == caed_pkg::TYPE_REPLY) begin
					kind_nx        = caed_pkg::KIND_REPLY;
					reply_start_nx = pend_q ? pend_addr_q : caed_pkg::NO_PENDING;
					reply_words_nx = pay_q[63:16];
					pend_nx        = 1'b0;
				end else begin
					bad_nx = bad_q + 32'd1;
				end
			end
			caed_pkg::CMD_REQUEST: begin
				kind_nx      = caed_pkg::KIND_REQUEST;
				pend_addr_nx = addr_q;
				pend_nx      = 1'b1;
				req_nx       = {caed_pkg::REQ_TAIL, addr_q, caed_pkg::REQ_READ,
					caed_pkg::REQ_HEAD1, caed_pkg::REQ_HEAD0};
			end
			caed_pkg::CMD_CLEAR: begin
				kind_nx        = caed_pkg::KIND_CLEARED;
				angle_nx       = '0;
				vel_nx         = '0;
				turns_nx       = '0;
				temp_nx        = '0;
				reply_start_nx = '0;
				reply_words_nx = '0;
				mtime_nx       = '0;
				ttime_nx       = '0;
				mseen_nx       = 1'b0;
				tseen_nx       = 1'b0;
				pend_addr_nx   = '0;
				pend_nx        = 1'b0;
				bad_nx         = '0;
			end
			default: kind_nx = caed_pkg::KIND_INVALID;
		endcase
		m_age = time_q - mtime_nx;
		t_age = time_q - ttime_nx;
	end

	// Commit stored state; a device_id write cancels the pending request unless an item commits in that cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q       <= '0;
			vel_q         <= '0;
			turns_q       <= '0;
			temp_q        <= '0;
			reply_start_q <= '0;
			reply_words_q <= '0;
			mtime_q       <= '0;
			ttime_q       <= '0;
			mseen_q       <= 1'b0;
			tseen_q       <= 1'b0;
			pend_addr_q   <= '0;
			pend_q        <= 1'b0;
			bad_q         <= '0;
		end else if (fire) begin
			angle_q       <= angle_nx;
			vel_q         <= vel_nx;
			turns_q       <= turns_nx;
			temp_q        <= temp_nx;
			reply_start_q <= reply_start_nx;
			reply_words_q <= reply_words_nx;
			mtime_q       <= mtime_nx;
			ttime_q       <= ttime_nx;
			mseen_q       <= mseen_nx;
			tseen_q       <= tseen_nx;
			pend_addr_q   <= pend_addr_nx;
			pend_q        <= pend_nx;
			bad_q         <= bad_nx;
		end else if (cfg.valid && (cfg.index == caed_pkg::REG_DEVICE_ID)) begin
			pend_q <= 1'b0;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_id_q     <= caed_pkg::DEVICE_ID_RST;
			sample_per_q <= caed_pkg::SAMPLE_PER_RST;
			stale_q      <= caed_pkg::STALE_LIMIT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				caed_pkg::REG_DEVICE_ID:   dev_id_q     <= cfg.data[10:0];
				caed_pkg::REG_SAMPLE_PER:  sample_per_q <= cfg.data[15:0];
				caed_pkg::REG_STALE_LIMIT: stale_q      <= cfg.data;
				default: ;
			endcase
		end
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.kind            <= kind_nx;
			out_q.angle_millideg  <= angle_nx;
			out_q.velocity_mdeg_s <= vel_nx;
			out_q.turns           <= turns_nx;
			out_q.temp_mdeg_c     <= temp_nx;
			out_q.reply_start     <= reply_start_nx;
			out_q.reply_words     <= reply_words_nx;
			out_q.request_bytes   <= req_nx;
			out_q.measure_fresh   <= mseen_nx && (m_age <= stale_q);
			out_q.temp_fresh      <= tseen_nx && (t_age <= stale_q);
			out_q.bad_frames      <= bad_nx;
		end
	end

	// Drive the channels
	assign item.ready          = (state_q == caed_pkg::ST_IDLE);
	assign cfg.ready           = 1'b1;
	assign res.valid           = out_valid_q;
	assign res.kind            = out_q.kind;
	assign res.angle_millideg  = out_q.angle_millideg;
	assign res.velocity_mdeg_s = out_q.velocity_mdeg_s;
	assign res.turns           = out_q.turns;
	assign res.temp_mdeg_c     = out_q.temp_mdeg_c;
	assign res.reply_start     = out_q.reply_start;
	assign res.reply_words     = out_q.reply_words;
	assign res.request_bytes   = out_q.request_bytes;
	assign res.measure_fresh   = out_q.measure_fresh;
	assign res.temp_fresh      = out_q.temp_fresh;
	assign res.bad_frames      = out_q.bad_frames;

endmodule
`default_nettype wire

### sim/can_angle_encoder_frame_decoder_core_test.sv
// Self-checking testbench for the angle encoder CAN frame decoder core.
// Depends on caed_pkg and the caed_in_if, caed_out_if and caed_cfg_if interfaces.
// A directed table runs first, then register settings with random traffic and idling.
`default_nettype none
module can_angle_encoder_frame_decoder_core_test;

	// Codes the package leaves unnamed
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam logic [1:0] REG_UNUSED  = 2'd3;
	// Quiet cycles allowed: room for a measurement through the serial divider, plus long stall runs
	localparam int QUIET_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 150;
	localparam int PHASE_COUNT   = 6;

	typedef struct {
		logic [1:0]  command;
		logic [28:0] rx_id;
		logic        rx_extended;
		logic [3:0]  rx_length;
		logic [63:0] rx_payload;
		logic [7:0]  reg_addr;
		logic [31:0] time_ms;
	} frame_cmd_t;

	typedef struct {
		frame_cmd_t      cmd;
		bit              typed;
		caed_pkg::kind_t kind;
		logic [31:0]     bad;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;

	caed_in_if  in_ch();
	caed_out_if out_ch();
	caed_cfg_if cfg_ch();

	can_angle_encoder_frame_decoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(in_ch),
		.res(out_ch),
		.cfg(cfg_ch)
	);

	// Register shadow
	logic [10:0] dev_id_q;
	logic [15:0] period_q;
	logic [31:0] stale_q;

	// Decoder state shadow
	logic [19:0]        angle_q;
	logic signed [31:0] speed_q;
	logic signed [15:0] turns_q;
	logic signed [19:0] temp_q;
	logic [7:0]         reply_addr_q;
	logic [47:0]        reply_words_q;
	logic [31:0]        meas_stamp;
	logic [31:0]        temp_stamp;
	logic               meas_valid;
	logic               temp_valid;
	logic [7:0]         req_addr;
	logic               req_open;
	logic [31:0]        bad_cnt;

	caed_pkg::out_item_t awaited_results[$];
	table_row_t          directed_rows[$];
	caed_pkg::out_item_t head_result;
	logic [31:0] clock_ms;
	int idle_pct;
	int stall_pct;
	int mismatches;
	int results_seen;
	int cmds_sent;

	// Clock, period 8
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void clear_store();
		angle_q = '0;
		speed_q = '0;
		turns_q = '0;
		temp_q = '0;
		reply_addr_q = '0;
		reply_words_q = '0;
		meas_stamp = '0;
		temp_stamp = '0;
		meas_valid = 1'b0;
		temp_valid = 1'b0;
		req_addr = '0;
		req_open = 1'b0;
		bad_cnt = '0;
	endfunction

	function automatic void apply_reg(logic [1:0] idx, logic [31:0] data);
		case (idx)
			caed_pkg::REG_DEVICE_ID: begin
				dev_id_q = data[10:0];
				req_open = 1'b0;
			end
			caed_pkg::REG_SAMPLE_PER: period_q = data[15:0];
			caed_pkg::REG_STALE_LIMIT: stale_q = data;
			default: ;
		endcase
	endfunction

	// Update the shadow state for one command and return its result item
	function automatic caed_pkg::out_item_t decode_command(frame_cmd_t c);
		caed_pkg::out_item_t r;
		logic [7:0] sync_b;
		logic [7:0] type_b;
		logic signed [63:0] wide;
		logic signed [63:0] divisor;
		logic [31:0] age;
		caed_pkg::kind_t k;
		sync_b = c.rx_payload[7:0];
		type_b = c.rx_payload[15:8];
		r = '0;
		k = caed_pkg::KIND_INVALID;
		case (c.command)
			caed_pkg::CMD_FRAME: begin
				if (c.rx_extended || c.rx_id != {18'd0, dev_id_q}) begin
					k = caed_pkg::KIND_NOT_ADDR;
				end else if (c.rx_length != caed_pkg::FRAME_LEN ||
						sync_b != caed_pkg::SYNC_BYTE) begin
					bad_cnt = bad_cnt + 32'd1;
				end else if (type_b == caed_pkg::TYPE_MEASURE) begin
					wide = {48'd0, c.rx_payload[31:16]};
					wide = (wide * 360000) / 32768;
					angle_q = wide[19:0];
					divisor = 64'sd32768 * ((period_q == 16'd0) ? 64'sd1 : {48'd0, period_q});
					wide = $signed(c.rx_payload[47:32]);
					wide = (wide * 64'sd3600000000) / divisor;
					if (wide > 64'sd2147483647)
						speed_q = caed_pkg::VEL_MAX;
					else if (wide < -64'sd2147483648)
						speed_q = caed_pkg::VEL_MIN;
					else
						speed_q = wide[31:0];
					turns_q = $signed(c.rx_payload[63:48]);
					meas_stamp = c.time_ms;
					meas_valid = 1'b1;
					k = caed_pkg::KIND_MEASURE;
				end else if (type_b == caed_pkg::TYPE_TEMP) begin
					wide = $signed(c.rx_payload[31:16]);
					wide = wide * 10;
					temp_q = wide[19:0];
					temp_stamp = c.time_ms;
					temp_valid = 1'b1;
					k = caed_pkg::KIND_TEMP;
				end else if (type_b == caed_pkg::TYPE_REPLY) begin
					reply_addr_q = req_open ? req_addr : caed_pkg::NO_PENDING;
					reply_words_q = c.rx_payload[63:16];
					req_open = 1'b0;
					k = caed_pkg::KIND_REPLY;
				end else begin
					bad_cnt = bad_cnt + 32'd1;
				end
			end
			caed_pkg::CMD_REQUEST: begin
				req_addr = c.reg_addr;
				req_open = 1'b1;
				r.request_bytes = {caed_pkg::REQ_TAIL, c.reg_addr, caed_pkg::REQ_READ,
					caed_pkg::REQ_HEAD1, caed_pkg::REQ_HEAD0};
				k = caed_pkg::KIND_REQUEST;
			end
			caed_pkg::CMD_CLEAR: begin
				clear_store();
				k = caed_pkg::KIND_CLEARED;
			end
			default: k = caed_pkg::KIND_INVALID;
		endcase
		r.kind = k;
		r.angle_millideg = angle_q;
		r.velocity_mdeg_s = speed_q;
		r.turns = turns_q;
		r.temp_mdeg_c = temp_q;
		r.reply_start = reply_addr_q;
		r.reply_words = reply_words_q;
		age = c.time_ms - meas_stamp;
		r.measure_fresh = meas_valid && (age <= stale_q);
		age = c.time_ms - temp_stamp;
		r.temp_fresh = temp_valid && (age <= stale_q);
		r.bad_frames = bad_cnt;
		return r;
	endfunction

	function automatic logic [63:0] frame_bytes(logic [7:0] sync_b, logic [7:0] type_b,
			logic [15:0] w2, logic [15:0] w4, logic [15:0] w6);
		return {w6, w4, w2, type_b, sync_b};
	endfunction

	task automatic add_row(logic [1:0] command, logic [28:0] id, logic ext, logic [3:0] len,
			logic [63:0] payload, logic [7:0] addr, logic [31:0] now, bit typed,
			caed_pkg::kind_t kind, logic [31:0] bad);
		table_row_t row;
		row.cmd.command = command;
		row.cmd.rx_id = id;
		row.cmd.rx_extended = ext;
		row.cmd.rx_length = len;
		row.cmd.rx_payload = payload;
		row.cmd.reg_addr = addr;
		row.cmd.time_ms = now;
		row.typed = typed;
		row.kind = kind;
		row.bad = bad;
		directed_rows.push_back(row);
	endtask

	// Mostly well-formed frames for the current sensor, the rest noise
	function automatic frame_cmd_t random_item();
		frame_cmd_t c;
		int pick;
		c.command = caed_pkg::CMD_FRAME;
		c.rx_id = {18'd0, dev_id_q};
		c.rx_extended = 1'b0;
		c.rx_length = caed_pkg::FRAME_LEN;
		c.rx_payload = {$urandom, $urandom};
		c.reg_addr = 8'($urandom);
		c.rx_payload[7:0] = caed_pkg::SYNC_BYTE;
		case ($urandom_range(0, 2))
			0: c.rx_payload[15:8] = caed_pkg::TYPE_MEASURE;
			1: c.rx_payload[15:8] = caed_pkg::TYPE_TEMP;
			default: c.rx_payload[15:8] = caed_pkg::TYPE_REPLY;
		endcase
		if ($urandom_range(0, 1) == 0)
			c.rx_payload[47:32] = 16'($urandom_range(0, 600)) - 16'd300;
		pick = $urandom_range(0, 99);
		if (pick < 62) begin
		end else if (pick < 72) begin
			c.command = caed_pkg::CMD_REQUEST;
		end else if (pick < 74) begin
			c.command = caed_pkg::CMD_CLEAR;
		end else if (pick < 76) begin
			c.command = CMD_UNKNOWN;
		end else if (pick < 82) begin
			c.rx_extended = 1'b1;
		end else if (pick < 88) begin
			if ($urandom_range(0, 1) == 0)
				c.rx_id = 29'($urandom);
			else
				c.rx_id = {18'd0, dev_id_q} | (29'd1 << $urandom_range(11, 28));
		end else if (pick < 93) begin
			c.rx_length = 4'($urandom);
		end else if (pick < 97) begin
			c.rx_payload[7:0] = 8'($urandom);
		end else begin
			c.rx_payload[15:8] = 8'($urandom);
		end
		// Advance time, often landing right at the stale boundary
		pick = $urandom_range(0, 99);
		if (pick < 60)
			clock_ms = clock_ms + $urandom_range(0, 30);
		else if (pick < 80)
			clock_ms = meas_stamp + stale_q - 32'd1 + 32'($urandom_range(0, 2));
		else if (pick < 90)
			clock_ms = temp_stamp + stale_q - 32'd1 + 32'($urandom_range(0, 2));
		else
			clock_ms = $urandom;
		c.time_ms = clock_ms;
		return c;
	endfunction

	// Present one item, hold it until taken, then record its expected result
	task automatic send_item(frame_cmd_t c, bit typed, caed_pkg::kind_t kind,
			logic [31:0] bad);
		caed_pkg::out_item_t want;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.command = c.command;
		in_ch.rx_id = c.rx_id;
		in_ch.rx_extended = c.rx_extended;
		in_ch.rx_length = c.rx_length;
		in_ch.rx_payload = c.rx_payload;
		in_ch.reg_addr = c.reg_addr;
		in_ch.time_ms = c.time_ms;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		want = decode_command(c);
		if (typed) begin
			want.kind = kind;
			want.bad_frames = bad;
		end
		awaited_results.push_back(want);
		cmds_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Drop valid and hold until every expected result has come back
	task automatic drain_results();
		in_ch.valid = 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// Receiver stalls
	always @(negedge clk)
		out_ch.ready = ($urandom_range(0, 99) >= stall_pct);

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (awaited_results.size() == 0) begin
				$error("result with nothing expected, kind %0d", out_ch.kind);
				mismatches++;
			end else begin
				head_result = awaited_results.pop_front();
				check_field("kind", head_result.kind, out_ch.kind);
				check_field("angle_millideg", head_result.angle_millideg,
					out_ch.angle_millideg);
				check_field("velocity_mdeg_s", head_result.velocity_mdeg_s,
					out_ch.velocity_mdeg_s);
				check_field("turns", head_result.turns, out_ch.turns);
				check_field("temp_mdeg_c", head_result.temp_mdeg_c, out_ch.temp_mdeg_c);
				check_field("reply_start", head_result.reply_start, out_ch.reply_start);
				check_field("reply_words", head_result.reply_words, out_ch.reply_words);
				check_field("request_bytes", head_result.request_bytes, out_ch.request_bytes);
				check_field("measure_fresh", head_result.measure_fresh, out_ch.measure_fresh);
				check_field("temp_fresh", head_result.temp_fresh, out_ch.temp_fresh);
				check_field("bad_frames", head_result.bad_frames, out_ch.bad_frames);
				results_seen++;
			end
		end
	end

	// Watchdog: end the run when no channel moves for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout after %0d quiet cycles", QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int phase;
		int step;
		frame_cmd_t c;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.command = caed_pkg::CMD_FRAME;
		in_ch.rx_id = '0;
		in_ch.rx_extended = 1'b0;
		in_ch.rx_length = '0;
		in_ch.rx_payload = '0;
		in_ch.reg_addr = '0;
		in_ch.time_ms = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = caed_pkg::REG_DEVICE_ID;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		results_seen = 0;
		cmds_sent = 0;
		clock_ms = '0;
		dev_id_q = caed_pkg::DEVICE_ID_RST;
		period_q = caed_pkg::SAMPLE_PER_RST;
		stale_q = caed_pkg::STALE_LIMIT_RST;
		clear_store();

		// Directed table; sensor id 0, period 10, stale limit 100 after reset
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b1, 4'd8,
			frame_bytes(8'h55, 8'h55, 16'h1, 16'h1, 16'h1),
			8'h00, 32'd0, 1'b1, caed_pkg::KIND_NOT_ADDR, 32'd0);
		add_row(caed_pkg::CMD_FRAME, 29'h1FFF_FFFF, 1'b0, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF,
			8'hFF, 32'hFFFF_FFFF, 1'b1, caed_pkg::KIND_NOT_ADDR, 32'd0);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd7,
			frame_bytes(8'h55, 8'h55, 16'h1, 16'h1, 16'h1),
			8'h00, 32'd0, 1'b1, caed_pkg::KIND_INVALID, 32'd1);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd15,
			frame_bytes(8'h55, 8'h56, 16'h1, 16'h1, 16'h1),
			8'h00, 32'd0, 1'b1, caed_pkg::KIND_INVALID, 32'd2);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd0,
			frame_bytes(8'h55, 8'h5F, 16'h1, 16'h1, 16'h1),
			8'h00, 32'd0, 1'b1, caed_pkg::KIND_INVALID, 32'd3);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd8,
			frame_bytes(8'h54, 8'h55, 16'h1, 16'h1, 16'h1),
			8'h00, 32'd0, 1'b1, caed_pkg::KIND_INVALID, 32'd4);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd8,
			frame_bytes(8'h55, 8'h57, 16'h1, 16'h1, 16'h1),
			8'h00, 32'd0, 1'b1, caed_pkg::KIND_INVALID, 32'd5);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd8,
			frame_bytes(8'h55, 8'h55, 16'hFFFF, 16'h7FFF, 16'h8000),
			8'h00, 32'd1000, 1'b1, caed_pkg::KIND_MEASURE, 32'd5);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd8,
			frame_bytes(8'h55, 8'h55, 16'h0000, 16'h8000, 16'h7FFF),
			8'h00, 32'd1100, 1'b0, caed_pkg::KIND_MEASURE, 32'd0);
		add_row(caed_pkg::CMD_FRAME, 29'd9, 1'b0, 4'd8, 64'd0, 8'h00, 32'd1200, 1'b0,
			caed_pkg::KIND_NOT_ADDR, 32'd0);
		add_row(caed_pkg::CMD_FRAME, 29'd9, 1'b0, 4'd8, 64'd0, 8'h00, 32'd1201, 1'b0,
			caed_pkg::KIND_NOT_ADDR, 32'd0);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd8,
			frame_bytes(8'h55, 8'h56, 16'h7FFF, 16'h0, 16'h0),
			8'h00, 32'd1300, 1'b1, caed_pkg::KIND_TEMP, 32'd5);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd8,
			frame_bytes(8'h55, 8'h56, 16'h8000, 16'h0, 16'h0),
			8'h00, 32'd1300, 1'b0, caed_pkg::KIND_TEMP, 32'd0);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd8,
			frame_bytes(8'h55, 8'h5F, 16'h1234, 16'h5678, 16'h9ABC),
			8'h00, 32'd1310, 1'b1, caed_pkg::KIND_REPLY, 32'd5);
		add_row(caed_pkg::CMD_REQUEST, 29'd0, 1'b0, 4'd0, 64'd0, 8'hFF, 32'd1320, 1'b1,
			caed_pkg::KIND_REQUEST, 32'd5);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd8,
			frame_bytes(8'h55, 8'h5F, 16'hFFFF, 16'hFFFF, 16'hFFFF),
			8'h00, 32'd1330, 1'b0, caed_pkg::KIND_REPLY, 32'd0);
		add_row(caed_pkg::CMD_REQUEST, 29'd0, 1'b0, 4'd0, 64'd0, 8'h00, 32'd1340, 1'b0,
			caed_pkg::KIND_REQUEST, 32'd0);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd8,
			frame_bytes(8'h55, 8'h5F, 16'h0, 16'h0, 16'h0),
			8'h00, 32'd1350, 1'b0, caed_pkg::KIND_REPLY, 32'd0);
		add_row(CMD_UNKNOWN, 29'h1FFF_FFFF, 1'b1, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF,
			32'd1360, 1'b1, caed_pkg::KIND_INVALID, 32'd5);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd8,
			frame_bytes(8'h55, 8'h55, 16'h4000, 16'h1, 16'h1),
			8'h00, 32'hFFFF_FFF0, 1'b0, caed_pkg::KIND_MEASURE, 32'd0);
		add_row(caed_pkg::CMD_FRAME, 29'd9, 1'b0, 4'd8, 64'd0, 8'h00, 32'h0000_0050, 1'b0,
			caed_pkg::KIND_NOT_ADDR, 32'd0);
		add_row(caed_pkg::CMD_CLEAR, 29'd0, 1'b0, 4'd0, 64'd0, 8'h00, 32'h0000_0060, 1'b1,
			caed_pkg::KIND_CLEARED, 32'd0);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd8,
			frame_bytes(8'h55, 8'h5F, 16'h1, 16'h2, 16'h3),
			8'h00, 32'd0, 1'b0, caed_pkg::KIND_REPLY, 32'd0);
		add_row(caed_pkg::CMD_FRAME, 29'd0, 1'b0, 4'd8,
			frame_bytes(8'h55, 8'h56, 16'h0001, 16'h0, 16'h0),
			8'h00, 32'd0, 1'b0, caed_pkg::KIND_TEMP, 32'd0);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].kind,
				directed_rows[i].bad);

		// Random traffic under several register settings and idling patterns
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			drain_results();
			case (phase)
				0: begin
					write_reg(caed_pkg::REG_DEVICE_ID, 32'hFFFF_FFFF);
					write_reg(caed_pkg::REG_SAMPLE_PER, 32'hFFFF_0001);
					write_reg(caed_pkg::REG_STALE_LIMIT, 32'd1);
					write_reg(REG_UNUSED, $urandom);
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					write_reg(caed_pkg::REG_DEVICE_ID, 32'd0);
					write_reg(caed_pkg::REG_SAMPLE_PER, 32'h0000_FFFF);
					write_reg(caed_pkg::REG_STALE_LIMIT, 32'hFFFF_FFFF);
					idle_pct = 60;
					stall_pct = 0;
				end
				2: begin
					write_reg(caed_pkg::REG_DEVICE_ID, $urandom);
					write_reg(caed_pkg::REG_SAMPLE_PER, 32'd0);
					write_reg(caed_pkg::REG_STALE_LIMIT, 32'd50);
					idle_pct = 0;
					stall_pct = 60;
				end
				3: begin
					write_reg(caed_pkg::REG_DEVICE_ID, $urandom);
					write_reg(caed_pkg::REG_SAMPLE_PER, $urandom_range(1, 65535));
					write_reg(caed_pkg::REG_STALE_LIMIT, $urandom_range(1, 3000));
					idle_pct = 25;
					stall_pct = 25;
				end
				4: begin
					write_reg(caed_pkg::REG_DEVICE_ID, $urandom);
					write_reg(caed_pkg::REG_SAMPLE_PER, 32'd10);
					write_reg(caed_pkg::REG_STALE_LIMIT, 32'd100);
					idle_pct = 0;
					stall_pct = 0;
				end
				default: begin
					write_reg(caed_pkg::REG_DEVICE_ID, $urandom);
					write_reg(caed_pkg::REG_SAMPLE_PER, $urandom_range(1, 20));
					write_reg(caed_pkg::REG_STALE_LIMIT, $urandom_range(1, 200));
					idle_pct = 25;
					stall_pct = 25;
				end
			endcase
			for (step = 0; step < PHASE_ITEMS; step++)
				send_item(random_item(), 1'b0, caed_pkg::KIND_INVALID, 32'd0);
			// Leave a request open so the next sensor id write cancels it
			c = random_item();
			c.command = caed_pkg::CMD_REQUEST;
			send_item(c, 1'b0, caed_pkg::KIND_INVALID, 32'd0);
		end

		drain_results();
		repeat (40) @(posedge clk);
		$display("%0d commands sent (%0d from the directed table), %0d register settings",
			cmds_sent, directed_rows.size(), PHASE_COUNT + 1);
		$display("%0d results compared field by field, %0d mismatches",
			results_seen, mismatches);
		if (mismatches == 0 && awaited_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
`default_nettype wire

### filelist.f
rtl/caed_pkg.sv
rtl/caed_in_if.sv
rtl/caed_out_if.sv
rtl/caed_cfg_if.sv
rtl/caed_div.sv
rtl/can_angle_encoder_frame_decoder_core.sv
sim/can_angle_encoder_frame_decoder_core_test.sv
